// ----- design/chirp_packet_airtime_estimator_top_macros.svh -----
// Assertion macros for the packet airtime estimator.
// Used by the top level; needs a signal named clock and one named reset in scope.
`ifndef CHIRP_PACKET_AIRTIME_ESTIMATOR_TOP_MACROS_SVH
`define CHIRP_PACKET_AIRTIME_ESTIMATOR_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CPAE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CPAE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/cpae_pkg.sv -----
// Shared types, constants and the reciprocal table of the airtime estimator.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpae_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 9;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SPREADING_FACTOR = 3'd0,
      CSR_BANDWIDTH_KHZ    = 3'd1,
      CSR_CODING_RATE      = 3'd2,
      CSR_PREAMBLE         = 3'd3,
      CSR_IMPLICIT_HEADER  = 3'd4,
      CSR_CRC_ENABLE       = 3'd5
   } csr_index_type;

   localparam logic [3:0] SF_RESET       = 4'd8;
   localparam logic [8:0] BW_RESET       = 9'd500;
   localparam logic [3:0] CR_RESET       = 4'd5;
   localparam logic [7:0] PREAMBLE_RESET = 8'd8;
   localparam logic       IMPLICIT_RESET = 1'b0;
   localparam logic       CRC_RESET      = 1'b1;

   localparam int unsigned AIR_W       = 20;
   localparam int unsigned SYM_W       = 10;
   localparam int unsigned BW_W        = 9;
   localparam int unsigned RECIP_W     = 17;
   localparam int unsigned RECIP_SHIFT = 16;
   localparam int unsigned DIV_STEPS   = 4;
   localparam int unsigned DIV_STAGES  = AIR_W / DIV_STEPS;

   localparam logic [AIR_W-1:0] AIR_MAX = '1;
   localparam logic [SYM_W-1:0] SYM_MAX = '1;

   typedef struct packed {
      logic [BW_W-1:0]  rem;
      logic [AIR_W-1:0] dividend;
      logic [AIR_W-1:0] quo;
      logic             sat;
      logic [SYM_W-1:0] psym;
      logic             low_rate;
   } div_word_type;

   // ceil(2^16 / d); exact floor division for dividends below 1024.
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         4'd10:   r = 17'd6554;
         4'd11:   r = 17'd5958;
         4'd12:   r = 17'd5462;
         4'd13:   r = 17'd5042;
         4'd14:   r = 17'd4682;
         4'd15:   r = 17'd4370;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/chirp_packet_airtime_estimator_top.sv -----
// Each accepted request word yields one response word, in order, from a registered pipeline.
// Throughput: one word per cycle; every stage holds its word under backpressure.
// The depth is set by the numerator, reciprocal multiply, symbol count and shift
// stages, followed by five divider stages that produce four quotient bits each.
// Reset is synchronous and active high; it empties the pipeline and restores
// the configuration registers to their defaults.
`default_nettype none
`include "chirp_packet_airtime_estimator_top_macros.svh"

module chirp_packet_airtime_estimator_top
   import cpae_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,  // [7:0] payload_length
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [31:0]           rsp_tdata   // [19:0] airtime_ms,
                                                  // [29:20] payload_symbols,
                                                  // [30] low_rate_optimize, [31] zero
);

   logic [3:0]      spreading_factor_ff;
   logic [BW_W-1:0] bandwidth_khz_ff;
   logic [3:0]      coding_rate_ff;
   logic [7:0]      preamble_ff;
   logic            implicit_header_ff;
   logic            crc_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spreading_factor_ff <= SF_RESET;
         bandwidth_khz_ff    <= BW_RESET;
         coding_rate_ff      <= CR_RESET;
         preamble_ff         <= PREAMBLE_RESET;
         implicit_header_ff  <= IMPLICIT_RESET;
         crc_enable_ff       <= CRC_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_SPREADING_FACTOR: spreading_factor_ff <= csr_wdata[3:0];
            CSR_BANDWIDTH_KHZ:    bandwidth_khz_ff    <= csr_wdata[BW_W-1:0];
            CSR_CODING_RATE:      coding_rate_ff      <= csr_wdata[3:0];
            CSR_PREAMBLE:         preamble_ff         <= csr_wdata[7:0];
            CSR_IMPLICIT_HEADER:  implicit_header_ff  <= csr_wdata[0];
            CSR_CRC_ENABLE:       crc_enable_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [BW_W-1:0] bw_eff;
   logic [15:0]     chips;
   logic            low_rate;
   logic [3:0]      sym_div;

   assign bw_eff   = (bandwidth_khz_ff == '0) ? BW_W'(1) : bandwidth_khz_ff;
   assign chips    = 16'(1) << spreading_factor_ff;
   assign low_rate = chips > {3'b0, bw_eff, 4'b0};
   assign sym_div  = spreading_factor_ff - {2'b0, low_rate, 1'b0};

   // Stage 1: quarter numerator, ceiling offset and divisor.
   logic        s1_valid_ff, s1_ready;
   logic [9:0]  s1_top_ff, s1_top_in;
   logic [3:0]  s1_div_ff;
   logic        s1_pos_ff, s1_pos_in;
   logic        s1_low_ff;
   logic signed [11:0] quarter_num;

   assign quarter_num = $signed({3'b0, req_tdata, 1'b0}) + 12'sd7
                      + $signed({9'b0, crc_enable_ff, 2'b0})
                      - $signed({8'b0, spreading_factor_ff})
                      - $signed({9'b0, implicit_header_ff, 1'b0, implicit_header_ff});
   assign s1_pos_in   = (quarter_num > 12'sd0) && (sym_div != 4'd0);
   assign s1_top_in   = s1_pos_in ? 10'(quarter_num[9:0] + {6'b0, sym_div} - 10'd1) : '0;

   // Stage 2: reciprocal multiply.
   logic        s2_valid_ff, s2_ready;
   logic [26:0] s2_prod_ff;
   logic        s2_pos_ff;
   logic        s2_low_ff;

   // Stage 3: payload symbols and quarter-symbol count.
   logic             s3_valid_ff, s3_ready;
   logic [15:0]      s3_quarters_ff, s3_quarters_in;
   logic [SYM_W-1:0] s3_psym_ff, s3_psym_in;
   logic             s3_low_ff;
   logic [9:0]       blocks;
   logic [12:0]      psym_full;

   assign blocks      = s2_prod_ff[RECIP_SHIFT+9:RECIP_SHIFT];
   assign psym_full   = s2_pos_ff ? 13'(13'd8 + blocks * coding_rate_ff) : 13'd8;
   assign s3_psym_in  = (psym_full[12:SYM_W] != '0) ? SYM_MAX : psym_full[SYM_W-1:0];
   assign s3_quarters_in = {6'b0, preamble_ff, 2'b0} + 16'd17 + {1'b0, psym_full, 2'b0};

   // Stage 4: scale by chips, add rounding term, set up the divider.
   logic         s4_valid_ff, s4_ready;
   div_word_type s4_word_ff, s4_word_in;
   logic [31:0]  scaled;
   logic [29:0]  dividend;

   assign scaled   = ({16'b0, s3_quarters_ff} << spreading_factor_ff)
                   + {22'b0, bw_eff, 1'b0};
   assign dividend = scaled[31:2];

   always_comb begin
      s4_word_in.sat      = dividend[29:AIR_W] >= {1'b0, bw_eff};
      s4_word_in.rem      = dividend[AIR_W+BW_W-1:AIR_W];
      s4_word_in.dividend = dividend[AIR_W-1:0];
      s4_word_in.quo      = '0;
      s4_word_in.psym     = s3_psym_ff;
      s4_word_in.low_rate = s3_low_ff;
   end

   logic         div_valid [DIV_STAGES+1];
   logic         div_ready [DIV_STAGES+1];
   div_word_type div_word  [DIV_STAGES+1];

   assign div_valid[0] = s4_valid_ff;
   assign div_word[0]  = s4_word_ff;

   assign s4_ready   = !s4_valid_ff || div_ready[0];
   assign s3_ready   = !s3_valid_ff || s4_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_tvalid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_top_ff <= s1_top_in;
         s1_div_ff <= sym_div;
         s1_pos_ff <= s1_pos_in;
         s1_low_ff <= low_rate;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_prod_ff <= s1_top_ff * recip(s1_div_ff);
         s2_pos_ff  <= s1_pos_ff;
         s2_low_ff  <= s1_low_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_quarters_ff <= s3_quarters_in;
         s3_psym_ff     <= s3_psym_in;
         s3_low_ff      <= s2_low_ff;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_word_ff <= s4_word_in;
      end
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      cpae_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_ready  (div_ready[g]),
         .in_word   (div_word[g]),
         .divisor   (bw_eff),
         .out_valid (div_valid[g+1]),
         .out_ready (div_ready[g+1]),
         .out_word  (div_word[g+1])
      );
   end

   div_word_type     last_word;
   logic [AIR_W-1:0] airtime;

   assign last_word             = div_word[DIV_STAGES];
   assign div_ready[DIV_STAGES] = rsp_tready;
   assign airtime    = last_word.sat ? AIR_MAX : last_word.quo;
   assign rsp_tvalid = div_valid[DIV_STAGES];
   assign rsp_tdata  = {1'b0, last_word.low_rate, last_word.psym, airtime};

   `CPAE_ASSERT_SAME(a_psym_floor, rsp_tvalid, rsp_tdata[29:20] >= 10'd8, "payload symbols below eight")
   `CPAE_ASSERT_SAME(a_low_rate_sf, rsp_tvalid && rsp_tdata[30], spreading_factor_ff >= 4'd5, "low rate with small spreading factor")
   `CPAE_ASSERT_SAME(a_div_rem, s4_valid_ff && !s4_word_ff.sat, s4_word_ff.rem < bw_eff, "divider remainder not below divisor")
   `CPAE_ASSERT_NEXT(a_pos_div, s1_valid_ff && s1_pos_ff && s2_ready, s2_prod_ff != '0, "zero product for positive numerator")

endmodule

`default_nettype wire

// ----- design/cpae_div_stage.sv -----
// One stage of the pipelined restoring divider: four quotient bits per word.
// Depends on cpae_pkg for the word type and step count.
`default_nettype none

module cpae_div_stage
   import cpae_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output      logic                 in_ready,
   input  wire div_word_type         in_word,
   input  wire logic [BW_W-1:0]      divisor,
   output      logic                 out_valid,
   input  wire logic                 out_ready,
   output      div_word_type         out_word
);

   logic         valid_ff;
   div_word_type word_ff;
   div_word_type word_in;

   always_comb begin
      logic [BW_W:0] trial;
      word_in = in_word;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {word_in.rem, word_in.dividend[AIR_W-1]};
         word_in.dividend = {word_in.dividend[AIR_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            word_in.rem = BW_W'(trial - {1'b0, divisor});
            word_in.quo = {word_in.quo[AIR_W-2:0], 1'b1};
         end else begin
            word_in.rem = trial[BW_W-1:0];
            word_in.quo = {word_in.quo[AIR_W-2:0], 1'b0};
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb_chirp_packet_airtime_estimator_top.sv -----
// Self-checking testbench for the packet airtime estimator top level.
// Predicts every response word from its own copy of the configuration and
// compares it with the block's output; needs only cpae_pkg and the top level.
`default_nettype none

module tb_chirp_packet_airtime_estimator_top
   import cpae_pkg::*;
();

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int PIPE_LATENCY = 9;
   localparam int RANDOM_ITEMS = 1630;

   typedef struct packed {
      logic [AIR_W-1:0] airtime;
      logic [SYM_W-1:0] symbols;
      logic             low_rate;
   } airtime_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;

   logic [3:0] cfg_sf       = SF_RESET;
   logic [8:0] cfg_bw       = BW_RESET;
   logic [3:0] cfg_cr       = CR_RESET;
   logic [7:0] cfg_preamble = PREAMBLE_RESET;
   logic       cfg_implicit = IMPLICIT_RESET;
   logic       cfg_crc      = CRC_RESET;

   airtime_result_type pending_airtimes[$];
   int mismatch_count = 0;
   int lengths_sent   = 0;
   int stall_left     = 0;
   bit tx_full_rate   = 1'b0;
   bit rx_full_rate   = 1'b0;

   chirp_packet_airtime_estimator_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] payload_length
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [19:0] airtime_ms, [29:20] payload_symbols,
                                 // [30] low_rate_optimize, [31] zero
   );

   always #10 clock = ~clock;

   function automatic airtime_result_type predict_airtime(input logic [7:0] len);
      airtime_result_type res;
      longint unsigned   bw;
      longint unsigned   chips;
      longint unsigned   blocks;
      longint unsigned   psym;
      longint unsigned   quarters;
      longint unsigned   air;
      int                num;
      int                den;
      logic              de;
      bw    = (cfg_bw == '0) ? 64'd1 : 64'(cfg_bw);
      chips = 64'd1 << cfg_sf;
      de    = (chips > 16 * bw);
      num   = 8 * int'(len) - 4 * int'(cfg_sf) + 28 + 16 * int'(cfg_crc)
              - 20 * int'(cfg_implicit);
      den   = 4 * (int'(cfg_sf) - 2 * int'(de));
      psym  = 8;
      if (num > 0 && den > 0) begin
         blocks = 64'((num + den - 1) / den);
         psym   = psym + blocks * 64'(cfg_cr);
      end
      quarters = 4 * 64'(cfg_preamble) + 17 + 4 * psym;
      air      = (quarters * chips + 2 * bw) / (4 * bw);
      res.airtime  = (air > 64'(AIR_MAX)) ? AIR_MAX : air[AIR_W-1:0];
      res.symbols  = (psym > 64'(SYM_MAX)) ? SYM_MAX : psym[SYM_W-1:0];
      res.low_rate = de;
      return res;
   endfunction

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SPREADING_FACTOR: cfg_sf       = value[3:0];
         CSR_BANDWIDTH_KHZ:    cfg_bw       = value[8:0];
         CSR_CODING_RATE:      cfg_cr       = value[3:0];
         CSR_PREAMBLE:         cfg_preamble = value[7:0];
         CSR_IMPLICIT_HEADER:  cfg_implicit = value[0];
         CSR_CRC_ENABLE:       cfg_crc      = value[0];
         default: ;
      endcase
   endtask

   task automatic write_config(input int sf, input int bw, input int cr,
                               input int pre, input int hdr, input int crc);
      csr_write(CSR_SPREADING_FACTOR, CSR_DATA_W'(sf));
      csr_write(CSR_BANDWIDTH_KHZ, CSR_DATA_W'(bw));
      csr_write(CSR_CODING_RATE, CSR_DATA_W'(cr));
      csr_write(CSR_PREAMBLE, CSR_DATA_W'(pre));
      csr_write(CSR_IMPLICIT_HEADER, CSR_DATA_W'(hdr));
      csr_write(CSR_CRC_ENABLE, CSR_DATA_W'(crc));
   endtask

   // The valid line stays high between back-to-back words and is only
   // lowered when a gap follows or when the queue is drained.
   task automatic send_length(input logic [7:0] len);
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (tx_full_rate || pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(5, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= len;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_airtimes.push_back(predict_airtime(len));
      lengths_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_airtimes.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (rx_full_rate) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 80) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin : rsp_check
      airtime_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_airtimes.size() == 0) begin
            $error("response word with no request outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_airtimes.pop_front();
            if (rsp_tdata[19:0] !== want.airtime) begin
               $error("airtime_ms expected %0d actual %0d", want.airtime, rsp_tdata[19:0]);
               mismatch_count++;
            end
            if (rsp_tdata[29:20] !== want.symbols) begin
               $error("payload_symbols expected %0d actual %0d",
                      want.symbols, rsp_tdata[29:20]);
               mismatch_count++;
            end
            if (rsp_tdata[30] !== want.low_rate) begin
               $error("low_rate_optimize expected %0d actual %0d",
                      want.low_rate, rsp_tdata[30]);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_reset_defaults;
      send_length(8'd0);
      send_length(8'd255);
      drain();
   endtask

   task automatic test_corner_settings;
      write_config(12, 7, 8, 255, 1, 0);
      send_length(8'd0);
      send_length(8'd255);
      drain();
      write_config(7, 500, 5, 6, 0, 1);
      send_length(8'd0);
      send_length(8'd255);
      drain();
      // Zero bandwidth behaves as one kilohertz.
      write_config(7, 0, 5, 8, 0, 1);
      send_length(8'd10);
      drain();
      write_config(0, 500, 5, 8, 0, 1);
      send_length(8'd100);
      drain();
      // Slowest symbol on the narrowest channel drives the airtime to saturation.
      write_config(15, 1, 15, 255, 0, 1);
      send_length(8'd255);
      drain();
      write_config(9, 125, 0, 8, 0, 1);
      send_length(8'd50);
      drain();
      csr_write(CSR_CODING_RATE, CSR_DATA_W'(4));
      send_length(8'd50);
      drain();
      csr_write(CSR_CODING_RATE, CSR_DATA_W'(15));
      send_length(8'd50);
      drain();
      // A tiny spreading factor with a heavy code overflows the symbol count.
      write_config(2, 500, 15, 255, 0, 1);
      send_length(8'd255);
      drain();
      write_config(5, 1, 6, 12, 1, 1);
      send_length(8'd17);
      drain();
   endtask

   task automatic test_ignored_index;
      csr_write(CSR_SPARE_LO, '1);
      csr_write(CSR_SPARE_HI, '0);
      send_length(8'd33);
      send_length(8'd200);
      drain();
   endtask

   task automatic randomise_config;
      if ($urandom_range(0, 4) == 0) begin
         write_config($urandom_range(0, 15), $urandom_range(0, 511), $urandom_range(0, 15),
                      $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
         write_config($urandom_range(7, 12),
                      ($urandom_range(0, 1) == 0) ? 125 << $urandom_range(0, 2)
                                                  : $urandom_range(7, 500),
                      $urandom_range(5, 8),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(6, 255)
                                                  : $urandom_range(6, 16),
                      $urandom_range(0, 1), $urandom_range(0, 1));
      end
   endtask

   task automatic test_random_phases;
      int target;
      int count;
      int pick;
      target = lengths_sent + RANDOM_ITEMS;
      while (lengths_sent < target) begin
         randomise_config();
         tx_full_rate = ($urandom_range(0, 3) == 0);
         rx_full_rate = ($urandom_range(0, 3) == 0);
         count = $urandom_range(10, 60);
         repeat (count) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) send_length(8'd0);
            else if (pick == 1) send_length(8'd255);
            else send_length(8'($urandom_range(0, 255)));
         end
         drain();
      end
      tx_full_rate = 1'b0;
      rx_full_rate = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_corner_settings();
      test_ignored_index();
      test_random_phases();
      drain();
      if (mismatch_count == 0 && pending_airtimes.size() == 0)
         $display("chirp_packet_airtime_estimator_top test passed");
      else
         $display("chirp_packet_airtime_estimator_top test failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("chirp_packet_airtime_estimator_top test failed");
      $finish;
   end

endmodule

`default_nettype wire
